FILE: hw/rtl/ptzcf_pkg.sv
// ptzcf_pkg: shared types and constants of the ptz camera command framer
// no dependencies

package ptzcf_pkg;

  typedef enum logic [3:0] {
    OP_RIGHT       = 4'd0,
    OP_LEFT        = 4'd1,
    OP_UP          = 4'd2,
    OP_DOWN        = 4'd3,
    OP_ZOOM_IN     = 4'd4,
    OP_ZOOM_OUT    = 4'd5,
    OP_LEFT_UP     = 4'd6,
    OP_LEFT_DOWN   = 4'd7,
    OP_RIGHT_UP    = 4'd8,
    OP_RIGHT_DOWN  = 4'd9,
    OP_STOP        = 4'd10,
    OP_GOTO_PRESET = 4'd11,
    OP_SET_PRESET  = 4'd12,
    OP_CLR_PRESET  = 4'd13,
    OP_FOCUS_NEAR  = 4'd14,
    OP_FOCUS_FAR   = 4'd15
  } op_e;

  localparam logic       PROTO_PELCO = 1'b0;
  localparam logic       PROTO_VISCA = 1'b1;

  localparam logic [0:0] CFG_PROTOCOL = 1'b0;
  localparam logic [0:0] CFG_ADDRESS  = 1'b1;

  localparam logic [7:0] PELCO_SYNC    = 8'hff;
  localparam logic [7:0] VISCA_HEADER  = 8'h80;
  localparam logic [7:0] VISCA_TERM    = 8'hff;
  localparam logic [7:0] ZOOM_TELE     = 8'h20;
  localparam logic [7:0] ZOOM_WIDE     = 8'h30;
  localparam logic [7:0] PRESET_CMD    = 8'h3f;
  localparam logic [7:0] ZOOM_DEFAULT  = 8'h04;

  localparam logic [3:0] PELCO_LAST_POS = 4'd6;
  localparam logic [3:0] VISCA_LAST_POS = 4'd8;
  localparam logic [1:0] STOP_LAST_FRM  = 2'd2;

  typedef struct packed {
    op_e        op;
    logic [7:0] speed1;
    logic [7:0] speed2;
    logic [7:0] preset;
    logic       proto;
    logic [7:0] addr;
  } cmd_t;

endpackage

FILE: hw/rtl/ptzcf_byte_gen.sv
// ptzcf_byte_gen: picks one byte of a pelco-d or visca frame from the held command
// depends on ptzcf_pkg

module ptzcf_byte_gen (
  input  ptzcf_pkg::cmd_t cmd_i,
  input  logic [1:0]      frame_i,
  input  logic [3:0]      pos_i,
  output logic [7:0]      byte_o
);

  logic [7:0] c1, c2, d1, d2, sum, zs;
  logic [7:0] pb [7];
  logic [7:0] vb [9];
  logic [7:0] pbyte, vbyte;

  // pelco-d command and data bytes
  always_comb begin
    c1 = 8'h00;
    c2 = 8'h00;
    d1 = 8'h00;
    d2 = 8'h00;
    unique case (cmd_i.op)
      ptzcf_pkg::OP_RIGHT:       begin c2 = 8'h02; d1 = cmd_i.speed1; end
      ptzcf_pkg::OP_LEFT:        begin c2 = 8'h04; d1 = cmd_i.speed1; end
      ptzcf_pkg::OP_UP:          begin c2 = 8'h08; d2 = cmd_i.speed1; end
      ptzcf_pkg::OP_DOWN:        begin c2 = 8'h10; d2 = cmd_i.speed1; end
      ptzcf_pkg::OP_ZOOM_IN:     c2 = 8'h20;
      ptzcf_pkg::OP_ZOOM_OUT:    c2 = 8'h40;
      ptzcf_pkg::OP_LEFT_UP:     begin c2 = 8'h0c; d1 = cmd_i.speed1; d2 = cmd_i.speed2; end
      ptzcf_pkg::OP_LEFT_DOWN:   begin c2 = 8'h14; d1 = cmd_i.speed1; d2 = cmd_i.speed2; end
      ptzcf_pkg::OP_RIGHT_UP:    begin c2 = 8'h0a; d1 = cmd_i.speed1; d2 = cmd_i.speed2; end
      ptzcf_pkg::OP_RIGHT_DOWN:  begin c2 = 8'h12; d1 = cmd_i.speed1; d2 = cmd_i.speed2; end
      ptzcf_pkg::OP_STOP:        c2 = 8'h00;
      ptzcf_pkg::OP_GOTO_PRESET: begin c2 = 8'h07; d2 = cmd_i.preset; end
      ptzcf_pkg::OP_SET_PRESET:  begin c2 = 8'h03; d2 = cmd_i.preset; end
      ptzcf_pkg::OP_CLR_PRESET:  begin c2 = 8'h05; d2 = cmd_i.preset; end
      ptzcf_pkg::OP_FOCUS_NEAR:  c2 = 8'h80;
      default:                   c1 = 8'h01;
    endcase
  end

  assign sum = cmd_i.addr + c1 + c2 + d1 + d2;

  assign pb[0] = ptzcf_pkg::PELCO_SYNC;
  assign pb[1] = cmd_i.addr;
  assign pb[2] = c1;
  assign pb[3] = c2;
  assign pb[4] = d1;
  assign pb[5] = d2;
  assign pb[6] = sum;

  // visca zoom speed falls back to the default outside 2..7
  assign zs = (cmd_i.speed1 < 8'd2 || cmd_i.speed1 > 8'd7) ? ptzcf_pkg::ZOOM_DEFAULT
                                                           : cmd_i.speed1;

  always_comb begin
    vb[0] = ptzcf_pkg::VISCA_HEADER + cmd_i.addr;
    vb[1] = 8'h01;
    vb[2] = 8'h06;
    vb[3] = 8'h01;
    vb[4] = 8'h00;
    vb[5] = 8'h00;
    vb[6] = 8'h00;
    vb[7] = 8'h00;
    vb[8] = ptzcf_pkg::VISCA_TERM;
    unique case (cmd_i.op)
      ptzcf_pkg::OP_RIGHT: begin
        vb[4] = cmd_i.speed1; vb[6] = 8'h02; vb[7] = 8'h03;
      end
      ptzcf_pkg::OP_LEFT: begin
        vb[4] = cmd_i.speed1; vb[6] = 8'h01; vb[7] = 8'h03;
      end
      ptzcf_pkg::OP_UP: begin
        vb[5] = cmd_i.speed1; vb[6] = 8'h03; vb[7] = 8'h01;
      end
      ptzcf_pkg::OP_DOWN: begin
        vb[5] = cmd_i.speed1; vb[6] = 8'h03; vb[7] = 8'h02;
      end
      ptzcf_pkg::OP_ZOOM_IN: begin
        vb[2] = 8'h04; vb[3] = 8'h07; vb[4] = ptzcf_pkg::ZOOM_TELE | zs;
        vb[5] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      ptzcf_pkg::OP_ZOOM_OUT: begin
        vb[2] = 8'h04; vb[3] = 8'h07; vb[4] = ptzcf_pkg::ZOOM_WIDE | zs;
        vb[5] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      ptzcf_pkg::OP_LEFT_UP: begin
        vb[4] = cmd_i.speed1; vb[5] = cmd_i.speed2; vb[6] = 8'h01; vb[7] = 8'h01;
      end
      ptzcf_pkg::OP_LEFT_DOWN: begin
        vb[4] = cmd_i.speed1; vb[5] = cmd_i.speed2; vb[6] = 8'h01; vb[7] = 8'h02;
      end
      ptzcf_pkg::OP_RIGHT_UP: begin
        vb[4] = cmd_i.speed1; vb[5] = cmd_i.speed2; vb[6] = 8'h02; vb[7] = 8'h01;
      end
      ptzcf_pkg::OP_RIGHT_DOWN: begin
        vb[4] = cmd_i.speed1; vb[5] = cmd_i.speed2; vb[6] = 8'h02; vb[7] = 8'h02;
      end
      ptzcf_pkg::OP_STOP: begin
        // pan-tilt stop, then zoom stop, then focus stop
        if (frame_i == 2'd0) begin
          vb[6] = 8'h03; vb[7] = 8'h03;
        end else begin
          vb[2] = 8'h04;
          vb[3] = (frame_i == 2'd1) ? 8'h07 : 8'h08;
          vb[5] = ptzcf_pkg::VISCA_TERM;
          vb[8] = 8'h00;
        end
      end
      ptzcf_pkg::OP_GOTO_PRESET: begin
        vb[2] = 8'h04; vb[3] = ptzcf_pkg::PRESET_CMD; vb[4] = 8'h02;
        vb[5] = cmd_i.preset; vb[6] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      ptzcf_pkg::OP_SET_PRESET: begin
        vb[2] = 8'h04; vb[3] = ptzcf_pkg::PRESET_CMD; vb[4] = 8'h01;
        vb[5] = cmd_i.preset; vb[6] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      ptzcf_pkg::OP_CLR_PRESET: begin
        vb[2] = 8'h04; vb[3] = ptzcf_pkg::PRESET_CMD; vb[4] = 8'h00;
        vb[5] = cmd_i.preset; vb[6] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      ptzcf_pkg::OP_FOCUS_NEAR: begin
        vb[2] = 8'h04; vb[3] = 8'h08; vb[4] = 8'h03;
        vb[5] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
      default: begin
        vb[2] = 8'h04; vb[3] = 8'h08; vb[4] = 8'h02;
        vb[5] = ptzcf_pkg::VISCA_TERM; vb[8] = 8'h00;
      end
    endcase
  end

  always_comb begin
    case (pos_i)
      4'd0:    pbyte = pb[0];
      4'd1:    pbyte = pb[1];
      4'd2:    pbyte = pb[2];
      4'd3:    pbyte = pb[3];
      4'd4:    pbyte = pb[4];
      4'd5:    pbyte = pb[5];
      4'd6:    pbyte = pb[6];
      default: pbyte = 8'h00;
    endcase
    case (pos_i)
      4'd0:    vbyte = vb[0];
      4'd1:    vbyte = vb[1];
      4'd2:    vbyte = vb[2];
      4'd3:    vbyte = vb[3];
      4'd4:    vbyte = vb[4];
      4'd5:    vbyte = vb[5];
      4'd6:    vbyte = vb[6];
      4'd7:    vbyte = vb[7];
      4'd8:    vbyte = vb[8];
      default: vbyte = 8'h00;
    endcase
  end

  assign byte_o = (cmd_i.proto == ptzcf_pkg::PROTO_VISCA) ? vbyte : pbyte;

endmodule

FILE: hw/rtl/ptz_camera_command_framer_core.sv
// ptz_camera_command_framer_core: top level, command register, byte sequencer, result register
// depends on ptzcf_pkg and ptzcf_byte_gen

// A command is taken when start is high and busy is low. It produces one
// result word per clock, marked by result_valid_o: 7 words for a Pelco-D
// frame, 9 for a VISCA frame and 27 for a VISCA stop (three frames). The
// byte counter walks the held command one position per cycle and frees the
// block after the last position of its final frame. busy drops
// while the final word of a command is being produced, so the next command
// can be taken then and its words follow with no gap. Results cannot be
// stalled. Write configuration only while busy is low and no words remain.

module ptz_camera_command_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] operation_i,
  input  logic [7:0] first_speed_i,
  input  logic [7:0] second_speed_i,
  input  logic [7:0] preset_number_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [7:0] frame_byte_o,
  output logic [3:0] byte_position_o,
  output logic       last_byte_o
);

  logic            proto_q;
  logic [7:0]      addr_q;
  ptzcf_pkg::cmd_t cmd_q, cmd_d;
  logic            active_q, active_d;
  logic [3:0]      pos_q, pos_d;
  logic [1:0]      frame_q, frame_d;
  logic            accept, frame_end, last_now;
  logic [7:0]      gen_byte;
  logic            valid_q;
  logic [7:0]      byte_q;
  logic [3:0]      bpos_q;
  logic            last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= ptzcf_pkg::PROTO_PELCO;
      addr_q  <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptzcf_pkg::CFG_PROTOCOL: proto_q <= cfg_data_i[0];
        default:                 addr_q  <= cfg_data_i;
      endcase
    end
  end

  assign frame_end = (cmd_q.proto == ptzcf_pkg::PROTO_VISCA)
                     ? (pos_q == ptzcf_pkg::VISCA_LAST_POS)
                     : (pos_q == ptzcf_pkg::PELCO_LAST_POS);
  assign last_now  = active_q && frame_end &&
                     (cmd_q.proto == ptzcf_pkg::PROTO_PELCO ||
                      cmd_q.op != ptzcf_pkg::OP_STOP ||
                      frame_q == ptzcf_pkg::STOP_LAST_FRM);
  assign busy      = active_q && !last_now;
  assign accept    = start && !busy;

  always_comb begin
    cmd_d    = cmd_q;
    active_d = active_q;
    pos_d    = pos_q;
    frame_d  = frame_q;
    if (accept) begin
      cmd_d.op     = ptzcf_pkg::op_e'(operation_i);
      cmd_d.speed1 = first_speed_i;
      cmd_d.speed2 = second_speed_i;
      cmd_d.preset = preset_number_i;
      cmd_d.proto  = proto_q;
      cmd_d.addr   = addr_q;
      active_d     = 1'b1;
      pos_d        = 4'd0;
      frame_d      = 2'd0;
    end else if (active_q) begin
      if (last_now) begin
        active_d = 1'b0;
      end else if (frame_end) begin
        pos_d   = 4'd0;
        frame_d = frame_q + 2'd1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= 4'd0;
      frame_q  <= 2'd0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      frame_q  <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  ptzcf_byte_gen u_byte_gen (
    .cmd_i   (cmd_q),
    .frame_i (frame_q),
    .pos_i   (pos_q),
    .byte_o  (gen_byte)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= gen_byte;
    bpos_q <= pos_q;
    last_q <= last_now;
  end

  assign result_valid_o  = valid_q;
  assign frame_byte_o    = byte_q;
  assign byte_position_o = bpos_q;
  assign last_byte_o     = last_q;

  // words of one command come out with no gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_byte_o |=> result_valid_o)
    else $error("gap inside a command");

  // a command ends only on a frame's closing position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_byte_o |->
      byte_position_o == ptzcf_pkg::PELCO_LAST_POS ||
      byte_position_o == ptzcf_pkg::VISCA_LAST_POS)
    else $error("last word at a wrong position");

  // while busy, the next cycle carries a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("busy without output");

  // a new command's first word follows at position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o && byte_position_o == 4'd0)
    else $error("command did not start at position zero");

endmodule
